// File: rtl/core/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants of the sync/length frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slfp_pkg;

  localparam int ByteW = 8;
  localparam int TimeW = 32;
  localparam int PlenW = 12;
  localparam int LenFieldW = 16;

  // sync word 'I','T','S','5'
  localparam logic [ByteW-1:0] Sync0 = 8'h49;
  localparam logic [ByteW-1:0] Sync1 = 8'h54;
  localparam logic [ByteW-1:0] Sync2 = 8'h53;
  localparam logic [ByteW-1:0] Sync3 = 8'h35;

  typedef struct packed {
    logic             has_byte;
    logic [ByteW-1:0] payload_byte;
    logic [TimeW-1:0] seconds;
    logic [TimeW-1:0] microseconds;
    logic [PlenW-1:0] payload_length;
    logic             last;
  } res_t;

  function automatic logic [ByteW-1:0] sync_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = Sync0;
      2'd1:    b = Sync1;
      2'd2:    b = Sync2;
      default: b = Sync3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/slfp_in_if.sv
// ----------------------------------------------------------------------------
// slfp_in_if
// Byte input channel: valid/ready handshake with one raw byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface slfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slfp_out_if.sv
// ----------------------------------------------------------------------------
// slfp_out_if
// Result channel: valid/ready handshake with one payload byte and frame info.
// ----------------------------------------------------------------------------
`default_nettype none

interface slfp_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  payload_byte;
  logic [31:0] seconds;
  logic [31:0] microseconds;
  logic [11:0] payload_length;
  logic        last;

  modport source (
    output valid, output has_byte, output payload_byte, output seconds,
    output microseconds, output payload_length, output last, input ready
  );
  modport sink (
    input valid, input has_byte, input payload_byte, input seconds,
    input microseconds, input payload_length, input last, output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/slfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// slfp_frame_fsm
// Frame state tracker: sync hunt, header capture and payload counting. Gives
// the result for the current byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module slfp_frame_fsm
  import slfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output      logic             res_valid_o,
  output      res_t             res_o
);

  localparam int PW = $clog2(MAX_PAYLOAD + 1);
  localparam int LW = (PW > PlenW) ? PW : PlenW;
  localparam logic [LenFieldW-1:0] MaxLen = LenFieldW'(MAX_PAYLOAD);

  localparam logic [3:0] PosHunt    = 4'd0;
  localparam logic [3:0] PosSync1   = 4'd1;
  localparam logic [3:0] PosSync2   = 4'd2;
  localparam logic [3:0] PosSync3   = 4'd3;
  localparam logic [3:0] PosSec0    = 4'd4;
  localparam logic [3:0] PosSec3    = 4'd7;
  localparam logic [3:0] PosUsec0   = 4'd8;
  localparam logic [3:0] PosUsec3   = 4'd11;
  localparam logic [3:0] PosLenLo   = 4'd12;
  localparam logic [3:0] PosLenHi   = 4'd13;
  localparam logic [3:0] PosPayload = 4'd14;

  logic [3:0]           pos_q, pos_d;
  logic [PW-1:0]        cnt_q, cnt_d;
  logic [ByteW-1:0]     len_lo_q, len_lo_d;
  logic [PW-1:0]        flen_q, flen_d;
  logic [TimeW-1:0]     sec_q, sec_d;
  logic [TimeW-1:0]     usec_q, usec_d;
  logic [LenFieldW-1:0] len16;
  logic [PW-1:0]        cnt_inc;
  logic                 is_last;
  logic [3:0]           hunt_pos;

  assign len16    = {data_byte_i, len_lo_q};
  assign cnt_inc  = cnt_q + PW'(1);
  assign is_last  = (cnt_inc == flen_q);
  assign hunt_pos = (data_byte_i == Sync0) ? PosSync1 : PosHunt;

  always_comb begin
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    len_lo_d = len_lo_q;
    flen_d   = flen_q;
    sec_d    = sec_q;
    usec_d   = usec_q;
    res_valid_o          = 1'b0;
    res_o.has_byte       = 1'b1;
    res_o.payload_byte   = data_byte_i;
    res_o.seconds        = sec_q;
    res_o.microseconds   = usec_q;
    res_o.payload_length = PlenW'(LW'(flen_q));
    res_o.last           = is_last;
    unique case (pos_q) inside
      PosHunt: begin
        pos_d = hunt_pos;
      end
      [PosSync1:PosSync3]: begin
        if (data_byte_i == sync_byte(pos_q[1:0])) begin
          pos_d = pos_q + 4'd1;
        end else begin
          pos_d = hunt_pos;
        end
      end
      [PosSec0:PosSec3]: begin
        sec_d[8*pos_q[1:0] +: 8] = data_byte_i;
        pos_d = pos_q + 4'd1;
      end
      [PosUsec0:PosUsec3]: begin
        usec_d[8*pos_q[1:0] +: 8] = data_byte_i;
        pos_d = pos_q + 4'd1;
      end
      PosLenLo: begin
        len_lo_d = data_byte_i;
        pos_d    = PosLenHi;
      end
      PosLenHi: begin
        if (len16 > MaxLen) begin
          pos_d = hunt_pos;
        end else begin
          flen_d = PW'(len16);
          cnt_d  = '0;
          if (len16 == '0) begin
            pos_d                = PosHunt;
            res_valid_o          = 1'b1;
            res_o.has_byte       = 1'b0;
            res_o.payload_byte   = '0;
            res_o.payload_length = '0;
            res_o.last           = 1'b1;
          end else begin
            pos_d = PosPayload;
          end
        end
      end
      PosPayload: begin
        res_valid_o = 1'b1;
        if (is_last) begin
          pos_d = PosHunt;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        pos_d = PosHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      cnt_q <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      len_lo_q <= len_lo_d;
      flen_q   <= flen_d;
      sec_q    <= sec_d;
      usec_q   <= usec_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Byte-stream frame parser for 'ITS5' sync, timestamped, length-prefixed frames.
// ----------------------------------------------------------------------------
// One byte is taken per item and every byte is handled combinationally, so
// the block sustains one item per clock. A result appears on the output in the
// cycle after the payload byte (or empty-frame length byte) that causes it and
// sits in a single output register; input ready is high whenever that register
// is empty or being drained, so only output back-pressure slows the stream.
// Header bytes and dropped bytes give no result. Frames longer than
// MAX_PAYLOAD bytes are discarded and the hunt restarts on the high length byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_parser
  import slfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  slfp_in_if.sink    data_in,
  slfp_out_if.source res_out
);

  logic in_fire;
  logic res_valid;
  res_t res;
  logic out_valid_q;
  res_t res_q;

  assign data_in.ready = !out_valid_q || res_out.ready;
  assign in_fire       = data_in.valid && data_in.ready;

  slfp_frame_fsm #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .data_byte_i(data_in.data_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      res_q <= res;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.has_byte       = res_q.has_byte;
  assign res_out.payload_byte   = res_q.payload_byte;
  assign res_out.seconds        = res_q.seconds;
  assign res_out.microseconds   = res_q.microseconds;
  assign res_out.payload_length = res_q.payload_length;
  assign res_out.last           = res_q.last;

  // empty frame result is always the closing one
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.has_byte |-> res.last)
    else $error("empty frame result not marked last");

  // empty frame carries zero length and zero byte
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.has_byte |-> res_q.payload_length == '0 &&
    res_q.payload_byte == '0)
    else $error("empty frame result carries data");

  // a result-producing item shows up on the output next cycle
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_valid |=> out_valid_q)
    else $error("result item lost");

  // no item taken while a held result is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_out.ready |-> !in_fire)
    else $error("output register overrun");

endmodule

`default_nettype wire
